// File: design/pgci_pkg.sv
// Shared types, widths and helpers for the position to grid cell index pipeline.
package pgci_pkg;

	localparam int POS_W              = 32;
	localparam int POS_FRAC_BITS      = 16;
	localparam int INV_W              = 32;
	localparam int INV_FRAC_BITS      = 16;
	localparam int SIZE_W             = 11;
	localparam int CELL_W             = 10;
	localparam int INDEX_W            = 30;
	localparam int MAX_CELLS_PER_AXIS = 1024;
	localparam int CFG_ADDR_W         = 3;

	// Difference, product and floor widths of the per-axis datapath, and the index row width.
	localparam int DIFF_W     = POS_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int PROD_SHIFT = POS_FRAC_BITS + INV_FRAC_BITS;
	localparam int FLOOR_W    = PROD_W - PROD_SHIFT;
	localparam int ROW_W      = CELL_W + SIZE_W;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CORNER_X      = 3'd0,
		REG_CORNER_Y      = 3'd1,
		REG_CORNER_Z      = 3'd2,
		REG_INV_CELL_SIZE = 3'd3,
		REG_GRID_SIZE_X   = 3'd4,
		REG_GRID_SIZE_Y   = 3'd5,
		REG_GRID_SIZE_Z   = 3'd6
	} cfg_reg_t;

	// Load enables of the five pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	// A size of zero counts as one cell, larger sizes saturate at the axis limit.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		if (s == '0) begin
			r = SIZE_W'(1);
		end else if (s > SIZE_W'(MAX_CELLS_PER_AXIS)) begin
			r = SIZE_W'(MAX_CELLS_PER_AXIS);
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

// File: design/position_to_grid_cell_index.sv
// Top level of the position to grid cell index pipeline.
// Each accepted word carries one Q16.16 particle position and leaves the last stage as the
// cell coordinates of a uniform 3-D grid, their row-major linear index and one clamp flag per
// axis. It takes one word in every cycle unless back pressure stops it, in five stages:
// corner subtract, the 33 by 33 bit scale multiply with exact floor, clamping into the grid,
// and two multiply-add stages for the index x*dy*dz + y*dz + z. Each stage holds its word
// when the next one is full and stalled, so an empty stage still takes a new word even while
// the output waits, and back pressure from the output costs no throughput once released.
// Configuration registers are written through cfg_we, cfg_addr and cfg_wdata, and should only
// change while no word is in flight. Grid sizes of zero count as one cell and sizes above 1024
// saturate at 1024. A cell below the grid becomes 0 and one above becomes size minus one, and
// the axis flag is raised in both cases.
module position_to_grid_cell_index (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input words.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [95:0]                         s_tdata,   // pos_x, pos_y, pos_z
	// Result words.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [63:0]                         m_tdata,   // cell_x, cell_y, cell_z,
	                                                       // linear_index, zero pad
	output logic [2:0]                          m_tuser,   // x_clamped, y_out_of_range,
	                                                       // z_out_of_range
	// Configuration writes.
	input  logic                                cfg_we,
	input  logic [pgci_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [31:0]                         cfg_wdata
);

	logic signed [pgci_pkg::POS_W-1:0]  corner_x_q;
	logic signed [pgci_pkg::POS_W-1:0]  corner_y_q;
	logic signed [pgci_pkg::POS_W-1:0]  corner_z_q;
	logic        [pgci_pkg::INV_W-1:0]  inv_cell_size_q;
	logic        [pgci_pkg::SIZE_W-1:0] size_x_q;
	logic        [pgci_pkg::SIZE_W-1:0] size_y_q;
	logic        [pgci_pkg::SIZE_W-1:0] size_z_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	pgci_pkg::stage_en_t en;

	logic [pgci_pkg::CELL_W-1:0]  cell_x_s3, cell_y_s3, cell_z_s3;
	logic                         flag_x_s3, flag_y_s3, flag_z_s3;
	logic [pgci_pkg::CELL_W-1:0]  cell_x_s5, cell_y_s5, cell_z_s5;
	logic [pgci_pkg::INDEX_W-1:0] index_s5;
	logic [2:0]                   flags_s5;

	// Sizes are stored already saturated, so the datapath never sees zero or an oversize.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_x_q      <= '0;
			corner_y_q      <= '0;
			corner_z_q      <= '0;
			inv_cell_size_q <= pgci_pkg::INV_W'(65536);
			size_x_q        <= pgci_pkg::SIZE_W'(1);
			size_y_q        <= pgci_pkg::SIZE_W'(1);
			size_z_q        <= pgci_pkg::SIZE_W'(1);
		end else if (cfg_we) begin
			case (pgci_pkg::cfg_reg_t'(cfg_addr))
				pgci_pkg::REG_CORNER_X:      corner_x_q      <= cfg_wdata;
				pgci_pkg::REG_CORNER_Y:      corner_y_q      <= cfg_wdata;
				pgci_pkg::REG_CORNER_Z:      corner_z_q      <= cfg_wdata;
				pgci_pkg::REG_INV_CELL_SIZE: inv_cell_size_q <= cfg_wdata;
				pgci_pkg::REG_GRID_SIZE_X:
					size_x_q <= pgci_pkg::eff_size(cfg_wdata[pgci_pkg::SIZE_W-1:0]);
				pgci_pkg::REG_GRID_SIZE_Y:
					size_y_q <= pgci_pkg::eff_size(cfg_wdata[pgci_pkg::SIZE_W-1:0]);
				pgci_pkg::REG_GRID_SIZE_Z:
					size_z_q <= pgci_pkg::eff_size(cfg_wdata[pgci_pkg::SIZE_W-1:0]);
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or when the stage after it loads too.
	always_comb begin
		en.s5 = !valid_s5 || m_tready;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign s_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	pgci_axis_bin u_axis_x (
		.clk           (clk),
		.en            (en),
		.pos           (s_tdata[31:0]),
		.corner        (corner_x_q),
		.inv_cell_size (inv_cell_size_q),
		.size          (size_x_q),
		.cell_s3       (cell_x_s3),
		.flag_s3       (flag_x_s3)
	);

	pgci_axis_bin u_axis_y (
		.clk           (clk),
		.en            (en),
		.pos           (s_tdata[63:32]),
		.corner        (corner_y_q),
		.inv_cell_size (inv_cell_size_q),
		.size          (size_y_q),
		.cell_s3       (cell_y_s3),
		.flag_s3       (flag_y_s3)
	);

	pgci_axis_bin u_axis_z (
		.clk           (clk),
		.en            (en),
		.pos           (s_tdata[95:64]),
		.corner        (corner_z_q),
		.inv_cell_size (inv_cell_size_q),
		.size          (size_z_q),
		.cell_s3       (cell_z_s3),
		.flag_s3       (flag_z_s3)
	);

	pgci_index u_index (
		.clk       (clk),
		.en        (en),
		.cell_x_s3 (cell_x_s3),
		.cell_y_s3 (cell_y_s3),
		.cell_z_s3 (cell_z_s3),
		.flags_s3  ({flag_z_s3, flag_y_s3, flag_x_s3}),
		.size_y    (size_y_q),
		.size_z    (size_z_q),
		.cell_x_s5 (cell_x_s5),
		.cell_y_s5 (cell_y_s5),
		.cell_z_s5 (cell_z_s5),
		.index_s5  (index_s5),
		.flags_s5  (flags_s5)
	);

	assign m_tvalid = valid_s5;
	assign m_tdata  = {4'b0000, index_s5, cell_z_s5, cell_y_s5, cell_x_s5};
	assign m_tuser  = flags_s5;

	// With the output open, every stage can move, so the input must be open as well.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while the output accepts");

	// A cell in the first row and column indexes by its z coordinate alone.
	a_index_origin_row: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && cell_x_s5 == '0 && cell_y_s5 == '0)
		|-> (index_s5 == pgci_pkg::INDEX_W'(cell_z_s5)))
		else $error("linear index disagrees with cell coordinates");

	// A stalled result word keeps its valid until taken.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && valid_s5 && !m_tready) |=> (valid_s4 && valid_s5))
		else $error("pipeline lost a word during a stall");

endmodule

// File: design/pgci_axis_bin.sv
// One axis: offset from the grid corner, scale, floor and clamp into the grid.
module pgci_axis_bin (
	input  logic                                clk,
	input  pgci_pkg::stage_en_t                 en,
	input  logic signed [pgci_pkg::POS_W-1:0]   pos,
	input  logic signed [pgci_pkg::POS_W-1:0]   corner,
	input  logic        [pgci_pkg::INV_W-1:0]   inv_cell_size,
	input  logic        [pgci_pkg::SIZE_W-1:0]  size,
	output logic        [pgci_pkg::CELL_W-1:0]  cell_s3,
	output logic                                flag_s3
);

	logic signed [pgci_pkg::DIFF_W-1:0]  diff_s1;
	logic signed [pgci_pkg::PROD_W-1:0]  prod;
	logic signed [pgci_pkg::FLOOR_W-1:0] floor_s2;
	logic        [pgci_pkg::CELL_W-1:0]  cell_d;
	logic                                flag_d;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			diff_s1 <= {pos[pgci_pkg::POS_W-1], pos} - {corner[pgci_pkg::POS_W-1], corner};
		end
	end

	// The signed product shifted right arithmetically is the exact floor.
	assign prod = diff_s1 * $signed({1'b0, inv_cell_size});

	always_ff @(posedge clk) begin
		if (en.s2) begin
			floor_s2 <= prod[pgci_pkg::PROD_W-1:pgci_pkg::PROD_SHIFT];
		end
	end

	always_comb begin
		if (floor_s2[pgci_pkg::FLOOR_W-1]) begin
			cell_d = '0;
			flag_d = 1'b1;
		end else if (floor_s2[pgci_pkg::FLOOR_W-2:0]
				>= (pgci_pkg::FLOOR_W-1)'(size)) begin
			cell_d = pgci_pkg::CELL_W'(size - pgci_pkg::SIZE_W'(1));
			flag_d = 1'b1;
		end else begin
			cell_d = floor_s2[pgci_pkg::CELL_W-1:0];
			flag_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			cell_s3 <= cell_d;
			flag_s3 <= flag_d;
		end
	end

endmodule

// File: design/pgci_index.sv
// Row-major linear index over two multiply stages; cells and flags ride along.
module pgci_index (
	input  logic                                clk,
	input  pgci_pkg::stage_en_t                 en,
	input  logic [pgci_pkg::CELL_W-1:0]         cell_x_s3,
	input  logic [pgci_pkg::CELL_W-1:0]         cell_y_s3,
	input  logic [pgci_pkg::CELL_W-1:0]         cell_z_s3,
	input  logic [2:0]                          flags_s3,
	input  logic [pgci_pkg::SIZE_W-1:0]         size_y,
	input  logic [pgci_pkg::SIZE_W-1:0]         size_z,
	output logic [pgci_pkg::CELL_W-1:0]         cell_x_s5,
	output logic [pgci_pkg::CELL_W-1:0]         cell_y_s5,
	output logic [pgci_pkg::CELL_W-1:0]         cell_z_s5,
	output logic [pgci_pkg::INDEX_W-1:0]        index_s5,
	output logic [2:0]                          flags_s5
);

	localparam int IDX_PROD_W = pgci_pkg::ROW_W + pgci_pkg::SIZE_W;

	logic [pgci_pkg::ROW_W-1:0]  row_s4;
	logic [pgci_pkg::CELL_W-1:0] cell_x_s4;
	logic [pgci_pkg::CELL_W-1:0] cell_y_s4;
	logic [pgci_pkg::CELL_W-1:0] cell_z_s4;
	logic [2:0]                  flags_s4;
	logic [IDX_PROD_W-1:0]       index_full;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			row_s4    <= pgci_pkg::ROW_W'(cell_x_s3) * pgci_pkg::ROW_W'(size_y)
				+ pgci_pkg::ROW_W'(cell_y_s3);
			cell_x_s4 <= cell_x_s3;
			cell_y_s4 <= cell_y_s3;
			cell_z_s4 <= cell_z_s3;
			flags_s4  <= flags_s3;
		end
	end

	assign index_full = IDX_PROD_W'(row_s4) * IDX_PROD_W'(size_z) + IDX_PROD_W'(cell_z_s4);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			index_s5  <= index_full[pgci_pkg::INDEX_W-1:0];
			cell_x_s5 <= cell_x_s4;
			cell_y_s5 <= cell_y_s4;
			cell_z_s5 <= cell_z_s4;
			flags_s5  <= flags_s4;
		end
	end

endmodule

// File: verif/position_to_grid_cell_index_tb.sv
// Self-checking testbench for the position to grid cell index pipeline.
`timescale 1ns / 100ps

module position_to_grid_cell_index_tb;

	localparam int CYCLE_LIMIT = 200000;
	// The receiver goes deaf for a long stretch once this many result words have arrived,
	// so that all five stages fill and the input side has to stall.
	localparam int HOLD_AT     = 250;
	localparam int HOLD_CYCLES = 400;
	// Cycles allowed after the last result for any stray word to show up.
	localparam int DRAIN_CYCLES = 20;
	// Register index past the end of the map; writes to it must change nothing.
	localparam logic [pgci_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

	// One particle position; z sits in the high bits so that the packed value is the tdata word.
	typedef struct packed {
		logic [pgci_pkg::POS_W-1:0] z;
		logic [pgci_pkg::POS_W-1:0] y;
		logic [pgci_pkg::POS_W-1:0] x;
	} position_t;

	typedef struct packed {
		logic [pgci_pkg::CELL_W-1:0]  cx;
		logic [pgci_pkg::CELL_W-1:0]  cy;
		logic [pgci_pkg::CELL_W-1:0]  cz;
		logic [pgci_pkg::INDEX_W-1:0] index;
		logic                         fx;
		logic                         fy;
		logic                         fz;
	} cell_result_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [95:0]                     s_tdata   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [63:0]                     m_tdata;
	logic [2:0]                      m_tuser;
	logic                            cfg_we    = 1'b0;
	logic [pgci_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [31:0]                     cfg_wdata = '0;

	// Our own copy of the grid registers, kept in step with every write.
	logic [31:0]                 grid_corner_x = '0;
	logic [31:0]                 grid_corner_y = '0;
	logic [31:0]                 grid_corner_z = '0;
	logic [31:0]                 grid_inv      = 32'd65536;
	logic [pgci_pkg::SIZE_W-1:0] grid_dim_x    = 11'd1;
	logic [pgci_pkg::SIZE_W-1:0] grid_dim_y    = 11'd1;
	logic [pgci_pkg::SIZE_W-1:0] grid_dim_z    = 11'd1;

	position_t    positions_q[$];   // positions not yet offered to the block
	cell_result_t cells_due_q[$];   // predicted results of accepted words, oldest first
	int           mismatches   = 0;
	int           words_out    = 0;
	int           hold_left    = 0;
	int           cycle_count  = 0;
	bit           steady       = 1'b0;   // when set, neither side inserts gaps

	position_to_grid_cell_index u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Zero and oversized grid dimensions are folded into the legal range of 1 to 1024.
	function automatic logic [pgci_pkg::SIZE_W-1:0] cells_along(
			input logic [pgci_pkg::SIZE_W-1:0] dim);
		if (dim == '0) return pgci_pkg::SIZE_W'(1);
		if (dim > pgci_pkg::SIZE_W'(pgci_pkg::MAX_CELLS_PER_AXIS))
			return pgci_pkg::SIZE_W'(pgci_pkg::MAX_CELLS_PER_AXIS);
		return dim;
	endfunction

	// Exact floor of (pos - corner) * inv on one axis, then clamping into the grid.
	// The difference needs 33 bits and the product 64; the cell is the product shifted
	// down by 32. A negative difference floors below zero unless the product is exactly
	// zero, so any nonzero product there means the cell fell below the grid.
	function automatic void floor_and_clamp(input logic [31:0] pos, input logic [31:0] corner,
			input logic [31:0] inv, input logic [pgci_pkg::SIZE_W-1:0] cells,
			output logic [pgci_pkg::CELL_W-1:0] cell_out, output logic clamped);
		logic signed [32:0] diff;
		logic [32:0]        mag;
		logic [63:0]        prod;
		diff = $signed({pos[31], pos}) - $signed({corner[31], corner});
		mag  = diff[32] ? 33'(-diff) : 33'(diff);
		prod = {31'b0, mag} * {32'b0, inv};
		cell_out = '0;
		clamped  = 1'b0;
		if (diff[32]) begin
			clamped = (prod != '0);
		end else if (prod[63:32] >= {21'b0, cells}) begin
			clamped  = 1'b1;
			cell_out = pgci_pkg::CELL_W'(cells - 1'b1);
		end else begin
			cell_out = prod[41:32];
		end
	endfunction

	// Full prediction for one position under the current register copy.
	function automatic cell_result_t bin_position(input position_t p);
		logic [pgci_pkg::SIZE_W-1:0] nx, ny, nz;
		logic [pgci_pkg::CELL_W-1:0] cx, cy, cz;
		logic                        fx, fy, fz;
		logic [63:0]                 idx;
		cell_result_t                r;
		nx = cells_along(grid_dim_x);
		ny = cells_along(grid_dim_y);
		nz = cells_along(grid_dim_z);
		floor_and_clamp(p.x, grid_corner_x, grid_inv, nx, cx, fx);
		floor_and_clamp(p.y, grid_corner_y, grid_inv, ny, cy, fy);
		floor_and_clamp(p.z, grid_corner_z, grid_inv, nz, cz, fz);
		idx = 64'(cx) * 64'(ny) * 64'(nz) + 64'(cy) * 64'(nz) + 64'(cz);
		r.cx    = cx;
		r.cy    = cy;
		r.cz    = cz;
		r.index = idx[pgci_pkg::INDEX_W-1:0];
		r.fx    = fx;
		r.fy    = fy;
		r.fz    = fz;
		return r;
	endfunction

	// Sender. A word stays on the bus until taken; the prediction is made at acceptance,
	// while the registers are known to be stable.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				cells_due_q = {cells_due_q, bin_position(position_t'(s_tdata))};
			end
			if (!s_tvalid || s_tready) begin
				if (positions_q.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
					s_tdata  <= positions_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Receiver. Each taken word is compared against the oldest prediction. It also owns
	// the long hold-off, counted here so that the sender keeps pushing meanwhile.
	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				words_out++;
				if (cells_due_q.size() == 0) begin
					$error("result word with no prediction pending: tdata %h tuser %b",
						m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = cells_due_q.pop_front();
					check_field("cell_x", want.cx, m_tdata[9:0]);
					check_field("cell_y", want.cy, m_tdata[19:10]);
					check_field("cell_z", want.cz, m_tdata[29:20]);
					check_field("linear_index", want.index, m_tdata[59:30]);
					check_field("x_clamped", want.fx, m_tuser[0]);
					check_field("y_out_of_range", want.fy, m_tuser[1]);
					check_field("z_out_of_range", want.fz, m_tuser[2]);
				end
				if (words_out == HOLD_AT) begin
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 11);
			end
		end
	end

	// One register write at the next rising edge; the write enable stays up for a run of
	// writes and is dropped by the caller.
	task automatic write_reg(input logic [pgci_pkg::CFG_ADDR_W-1:0] addr,
			input logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		case (addr)
			pgci_pkg::REG_CORNER_X:      grid_corner_x = value;
			pgci_pkg::REG_CORNER_Y:      grid_corner_y = value;
			pgci_pkg::REG_CORNER_Z:      grid_corner_z = value;
			pgci_pkg::REG_INV_CELL_SIZE: grid_inv      = value;
			pgci_pkg::REG_GRID_SIZE_X:   grid_dim_x    = value[pgci_pkg::SIZE_W-1:0];
			pgci_pkg::REG_GRID_SIZE_Y:   grid_dim_y    = value[pgci_pkg::SIZE_W-1:0];
			pgci_pkg::REG_GRID_SIZE_Z:   grid_dim_z    = value[pgci_pkg::SIZE_W-1:0];
			default: ;
		endcase
	endtask

	// Loads the whole grid description, plus a stray write to the unmapped index.
	task automatic load_grid(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] cz, input logic [31:0] inv,
			input logic [pgci_pkg::SIZE_W-1:0] dx, input logic [pgci_pkg::SIZE_W-1:0] dy,
			input logic [pgci_pkg::SIZE_W-1:0] dz);
		write_reg(pgci_pkg::REG_CORNER_X, cx);
		write_reg(pgci_pkg::REG_CORNER_Y, cy);
		write_reg(pgci_pkg::REG_CORNER_Z, cz);
		write_reg(pgci_pkg::REG_INV_CELL_SIZE, inv);
		write_reg(pgci_pkg::REG_GRID_SIZE_X, {21'b0, dx});
		write_reg(pgci_pkg::REG_GRID_SIZE_Y, {21'b0, dy});
		write_reg(pgci_pkg::REG_GRID_SIZE_Z, {21'b0, dz});
		write_reg(REG_UNMAPPED, $urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Returns once every queued position has been taken and every result checked. Every
	// word yields exactly one result, so the pipeline is empty at that point.
	task automatic wait_drained();
		@(negedge clk);
		while (positions_q.size() != 0 || s_tvalid || cells_due_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic queue_position(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		position_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		positions_q = {positions_q, p};
	endtask

	// A coordinate that lands in or near the given cell: the cell index plus a random
	// fraction is divided back through the scale and the corner added, saturating at
	// the ends of the Q16.16 range.
	function automatic logic [31:0] coord_near_cell(input int cell_num,
			input logic [31:0] corner, input logic [31:0] inv);
		longint      target;
		longint      p;
		logic [31:0] frac;
		int          pick;
		if (inv == '0) return $urandom;
		pick = $urandom_range(9);
		frac = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
		target = (longint'(cell_num) <<< 32) + longint'({32'b0, frac});
		p = longint'($signed(corner)) + target / longint'({32'b0, inv});
		if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
		if (p < -64'sh8000_0000) p = -64'sh8000_0000;
		return p[31:0];
	endfunction

	// Mostly positions inside the grid, weighted toward its faces, with a share just
	// outside on either side and some fully random values.
	function automatic logic [31:0] pick_coord(input logic [31:0] corner,
			input logic [31:0] inv, input logic [pgci_pkg::SIZE_W-1:0] dim);
		int n;
		int c;
		int r;
		n = int'(cells_along(dim));
		r = $urandom_range(99);
		if (r < 15) return $urandom;
		if (r < 30) begin
			case ($urandom_range(3))
				0:       c = -1;
				1:       c = -2;
				2:       c = n;
				default: c = n + 1;
			endcase
		end else if (r < 40) begin
			c = $urandom_range(1) ? 0 : n - 1;
		end else begin
			c = $urandom_range(n - 1, 0);
		end
		return coord_near_cell(c, corner, inv);
	endfunction

	task automatic queue_positions(input int count);
		repeat (count) begin
			queue_position(pick_coord(grid_corner_x, grid_inv, grid_dim_x),
				pick_coord(grid_corner_y, grid_inv, grid_dim_y),
				pick_coord(grid_corner_z, grid_inv, grid_dim_z));
		end
	endtask

	function automatic logic [31:0] random_corner();
		return $urandom_range(1) ? $urandom : 32'($signed($urandom_range(2000000)) - 1000000);
	endfunction

	function automatic logic [31:0] random_scale();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(32'h0010_0000, 32'h0000_4000);
			4, 5:       return 32'd65536 * $urandom_range(64, 1);
			6, 7:       return $urandom;
			8:          return $urandom_range(1);
			default:    return 32'hFFFF_FFFF;
		endcase
	endfunction

	// Mostly small grids, some up to the full 1024, a few zero or oversized.
	function automatic logic [pgci_pkg::SIZE_W-1:0] random_dim();
		int r;
		r = $urandom_range(99);
		if (r < 60) return pgci_pkg::SIZE_W'($urandom_range(16, 1));
		if (r < 85) return pgci_pkg::SIZE_W'($urandom_range(pgci_pkg::MAX_CELLS_PER_AXIS, 1));
		if (r < 90) return '0;
		return pgci_pkg::SIZE_W'($urandom_range(2047, pgci_pkg::MAX_CELLS_PER_AXIS + 1));
	endfunction

	// Test sequence: reset, directed corner cases, then randomized grids.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset grid: a single cell of unit size at the origin, so any position off it
		// lands on cell zero with the flag raised.
		queue_position(32'h0, 32'h0, 32'h0);
		queue_position(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_position(32'h0000_FFFF, 32'h0001_0000, 32'h8000_0001);
		wait_drained();

		// Full 1024 cube with unit cells: last cell, exactly on the top face, one LSB
		// below the bottom face, and the ends of the position range.
		load_grid(32'h0, 32'h0, 32'h0, 32'd65536, 11'd1024, 11'd1024, 11'd1024);
		queue_position(32'h0, 32'h0, 32'h0);
		queue_position(32'h03FF_FFFF, 32'h03FF_FFFF, 32'h03FF_FFFF);
		queue_position(32'h0400_0000, 32'h0400_0000, 32'h0400_0000);
		queue_position(32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_FFFF);
		queue_position(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		queue_position(32'h0001_0000, 32'h0002_0000, 32'h03FF_0000);
		wait_drained();

		// Extreme corners with the largest scale, a zero size, the largest encodable
		// size and one just above the limit: differences span the full 33 bits.
		load_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			11'd0, 11'd2047, 11'd1025);
		queue_position(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		queue_position(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_position(32'h0, 32'h0, 32'h0);
		queue_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		wait_drained();

		// A zero scale maps everything to cell zero with no flag, on either side.
		load_grid(32'h1234_5678, 32'hEDCB_A988, 32'h0, 32'h0, 11'd5, 11'd6, 11'd7);
		queue_position(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_position(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		wait_drained();

		// Random grids; one of them runs with both sides flat out.
		for (int ph = 0; ph < 10; ph++) begin
			load_grid(random_corner(), random_corner(), random_corner(), random_scale(),
				random_dim(), random_dim(), random_dim());
			steady = (ph == 5);
			queue_positions(150);
			wait_drained();
		end
		steady = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: files.f
design/pgci_pkg.sv
design/pgci_axis_bin.sv
design/pgci_index.sv
design/position_to_grid_cell_index.sv
verif/position_to_grid_cell_index_tb.sv
